[hdl/ovn_pkg.sv]
// ----------------------------------------------------------------------------
// ovn_pkg
// Shared widths, register indexes, hash constants and the raised-cosine
// weight generator for the octave value-noise block.
// ----------------------------------------------------------------------------
package ovn_pkg;

   // Field and datapath widths.
   localparam int POSITION_W = 24;
   localparam int RESULT_W   = 20;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int BASE_W     = 4;
   localparam int GAIN_W     = 16;
   localparam int LATTICE_W  = 17;
   localparam int VALUE_W    = 32;
   localparam int WEIGHT_W   = 17;
   localparam int MAX_OCTAVES = 4;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_LOG2 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN0     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN1     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN2     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN3     = 3'd4;

   // Register reset values.
   localparam logic [BASE_W-1:0] BASE_RESET  = 4'd7;
   localparam logic [GAIN_W-1:0] GAIN0_RESET = 16'd32768;
   localparam logic [GAIN_W-1:0] GAIN1_RESET = 16'd16384;
   localparam logic [GAIN_W-1:0] GAIN2_RESET = 16'd6554;
   localparam logic [GAIN_W-1:0] GAIN3_RESET = 16'd1966;
   localparam logic [BASE_W-1:0] MIN_BASE_LOG2 = 4'd3;

   // Lattice hash constants; only the low 31 bits of the hash survive.
   localparam logic [30:0] HASH_MUL  = 31'd15731;
   localparam logic [30:0] HASH_ADD1 = 31'd789221;
   localparam logic [30:0] HASH_ADD2 = 31'd1376312589;
   localparam logic signed [VALUE_W-1:0] VALUE_ONE = 32'sh4000_0000;

   // Output rails of signed Q4.16.
   localparam logic signed [21:0] OUT_MAX = 22'sd524287;
   localparam logic signed [21:0] OUT_MIN = -22'sd524288;

   localparam logic [63:0] ONE_Q30 = 64'h0000_0000_4000_0000;
   localparam logic [63:0] PI_Q30  = 64'd3373259426;

   // Raised-cosine weight (1 - cos(pi*t))/2 in Q0.16 for table entry idx of
   // a table with 2^tbits entries. The cosine is a six-term Horner series in
   // Q2.30, and the upper half of the table mirrors the lower half.
   function automatic logic [WEIGHT_W-1:0] cos_weight(input int unsigned idx,
                                                      input int unsigned tbits);
      logic [63:0] theta;
      logic [63:0] x2;
      logic [63:0] r;
      logic [63:0] t;
      logic [63:0] w;
      int unsigned size;
      int unsigned half;
      int unsigned j;
      size = 32'd1 << tbits;
      half = size >> 1;
      j = (idx <= half) ? idx : size - idx;
      theta = (PI_Q30 * 64'(j)) >> tbits;
      x2 = (theta * theta) >> 30;
      r = ONE_Q30;
      for (int k = 0; k < 6; k++) begin
         t = (x2 * r) >> 30;
         unique case (k)
            0: t = t / 64'd132;
            1: t = t / 64'd90;
            2: t = t / 64'd56;
            3: t = t / 64'd30;
            4: t = t / 64'd12;
            default: t = t / 64'd2;
         endcase
         r = (t > ONE_Q30) ? 64'd0 : ONE_Q30 - t;
      end
      w = (ONE_Q30 - r + 64'd16384) >> 15;
      if (w > 64'd65536) begin
         w = 64'd65536;
      end
      if (idx > half) begin
         w = 64'd65536 - w;
      end
      return w[WEIGHT_W-1:0];
   endfunction

endpackage

[hdl/octave_value_noise_1d.sv]
// ----------------------------------------------------------------------------
// octave_value_noise_1d
// Four-octave one-dimensional value noise with cosine blending, one sample
// per clock.
// ----------------------------------------------------------------------------
// Usage: a request beat is taken at every rising edge where start is high and
// busy is low. busy is always low, so a new position may be offered in every
// cycle. Each request produces exactly one response beat: rsp_valid is high
// for one cycle with rsp_noise_value (signed Q4.16) and rsp_saturated.
// The throughput is one beat per cycle. The depth is set by the input
// stage that captures the lattice points and the weight, the lattice hash,
// which spends one stage on each of its three multiplies, the stage that
// forms the value difference, then the blend multiply, the gain multiply,
// the octave sum and the rounding and saturation stage.
// The receiver cannot stall, so there is no back-pressure; results simply
// leave the pipeline in order. Synchronous reset empties the pipeline and
// restores the configuration registers to their defaults. The configuration
// port writes one register per cycle with no wait and should be used only
// while no request is in flight.
// ----------------------------------------------------------------------------
module octave_value_noise_1d #(
   parameter int NUM_OCTAVES       = 4,
   parameter int WEIGHT_TABLE_BITS = 8
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic [ovn_pkg::POSITION_W-1:0]         req_position,
   output logic                                   rsp_valid,
   output logic signed [ovn_pkg::RESULT_W-1:0]    rsp_noise_value,
   output logic                                   rsp_saturated,
   input  logic                                   csr_we,
   input  logic [ovn_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [ovn_pkg::CSR_DATA_W-1:0]         csr_wdata
);
   import ovn_pkg::*;

   localparam int TABLE_SIZE = 1 << WEIGHT_TABLE_BITS;
   localparam int LATENCY    = 9;
   localparam int MID_STAGES = LATENCY - 1;
   localparam int TERM_W     = VALUE_W + GAIN_W + 1;
   localparam int BLEND_W    = 51;
   localparam int SUM_W      = TERM_W + 2;
   localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(64'd268435456);

   typedef logic [WEIGHT_W-1:0] wtab_type [TABLE_SIZE];

   function automatic wtab_type build_wtab();
      wtab_type tab;
      for (int i = 0; i < TABLE_SIZE; i++) begin
         tab[i] = cos_weight(i, WEIGHT_TABLE_BITS);
      end
      return tab;
   endfunction

   // The cosine weight table is built at elaboration and read as logic.
   localparam wtab_type WTAB = build_wtab();

   // Configuration registers.
   logic [BASE_W-1:0] base_ff;
   logic [GAIN_W-1:0] gain_ff [MAX_OCTAVES];
   logic [BASE_W-1:0] base_eff;

   // One valid bit per stage, plus the response strobe at the end.
   logic [MID_STAGES-1:0] vld_ff;
   logic                  rsp_valid_ff;

   logic signed [TERM_W-1:0] term7_ff [NUM_OCTAVES];
   logic signed [SUM_W-1:0]  sum8_ff;
   logic signed [SUM_W-1:0]  sum8_in;
   logic signed [SUM_W-1:0]  rounded;
   logic signed [21:0]       quot;
   logic signed [RESULT_W-1:0] rsp_value_ff;
   logic signed [RESULT_W-1:0] rsp_value_in;
   logic                     rsp_sat_ff;
   logic                     rsp_sat_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff    <= BASE_RESET;
         gain_ff[0] <= GAIN0_RESET;
         gain_ff[1] <= GAIN1_RESET;
         gain_ff[2] <= GAIN2_RESET;
         gain_ff[3] <= GAIN3_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_BASE_LOG2: base_ff    <= csr_wdata[BASE_W-1:0];
            CSR_GAIN0:     gain_ff[0] <= csr_wdata;
            CSR_GAIN1:     gain_ff[1] <= csr_wdata;
            CSR_GAIN2:     gain_ff[2] <= csr_wdata;
            CSR_GAIN3:     gain_ff[3] <= csr_wdata;
            default: ;  // Indexes past the register list are dropped.
         endcase
      end
   end

   // A coarsest period below eight units is raised to eight.
   assign base_eff = (base_ff < MIN_BASE_LOG2) ? MIN_BASE_LOG2 : base_ff;

   // Every beat moves forward each cycle; the receiver never holds off.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         vld_ff       <= {vld_ff[MID_STAGES-2:0], start & ~busy};
         rsp_valid_ff <= vld_ff[MID_STAGES-1];
      end
   end

   // One lane per octave. Octave k uses a period of 2^(base - k) units.
   for (genvar k = 0; k < NUM_OCTAVES; k++) begin : g_oct
      logic [BASE_W-1:0]    p;
      logic [15:0]          lo_in;
      logic [LATTICE_W-1:0] hi_in;
      logic [POSITION_W-1:0] frac_al;
      logic [WEIGHT_W-1:0]  w_in;
      logic [LATTICE_W-1:0] n_lo_ff;
      logic [LATTICE_W-1:0] n_hi_ff;
      logic [WEIGHT_W-1:0]  w1_ff;
      logic [WEIGHT_W-1:0]  w2_ff;
      logic [WEIGHT_W-1:0]  w3_ff;
      logic [WEIGHT_W-1:0]  w4_ff;
      logic [WEIGHT_W-1:0]  w5_ff;
      logic signed [VALUE_W-1:0] val_lo;
      logic signed [VALUE_W-1:0] val_hi;
      logic signed [VALUE_W-1:0] a5_ff;
      logic signed [VALUE_W:0]   diff5_ff;
      logic signed [BLEND_W-1:0] blend;
      logic signed [VALUE_W-1:0] v6_ff;
      logic signed [TERM_W-1:0]  term_in;

      // Lattice points around the position and the blend weight. The
      // fraction is left-aligned so that its top bits index the table, with
      // zeros filling in below a fraction shorter than the index.
      always_comb begin
         p       = base_eff - BASE_W'(k);
         lo_in   = req_position[POSITION_W-1:8] & (16'hFFFF << p);
         hi_in   = {1'b0, lo_in} + (LATTICE_W'(1) << p);
         frac_al = req_position << (5'd16 - {1'b0, p});
         w_in    = WTAB[frac_al[POSITION_W-1 -: WEIGHT_TABLE_BITS]];
      end

      always_ff @(posedge clock) begin
         n_lo_ff <= {1'b0, lo_in};
         n_hi_ff <= hi_in;
         w1_ff   <= w_in;
         w2_ff   <= w1_ff;
         w3_ff   <= w2_ff;
         w4_ff   <= w3_ff;
      end

      ovn_hash u_hash_lo (
         .clock         (clock),
         .n             (n_lo_ff),
         .lattice_value (val_lo)
      );

      ovn_hash u_hash_hi (
         .clock         (clock),
         .n             (n_hi_ff),
         .lattice_value (val_hi)
      );

      // Blend as a*65536 + (b - a)*w, which equals a*(65536 - w) + b*w.
      // Dropping the low 16 bits of the blend is the floor to Q2.30.
      always_comb begin
         blend = (BLEND_W'(a5_ff) <<< 16)
               + BLEND_W'(diff5_ff) * BLEND_W'($signed({1'b0, w5_ff}));
         term_in = TERM_W'(v6_ff) * TERM_W'($signed({1'b0, gain_ff[k]}));
      end

      always_ff @(posedge clock) begin
         a5_ff        <= val_lo;
         diff5_ff     <= (VALUE_W+1)'(val_hi) - (VALUE_W+1)'(val_lo);
         w5_ff        <= w4_ff;
         v6_ff        <= blend[VALUE_W+15:16];
         term7_ff[k]  <= term_in;
      end
   end

   always_comb begin
      sum8_in = '0;
      for (int k = 0; k < NUM_OCTAVES; k++) begin
         sum8_in = sum8_in + SUM_W'(term7_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      sum8_ff <= sum8_in;
   end

   // Round half up from Q45 to Q16, then clip to the Q4.16 range.
   always_comb begin
      rounded = sum8_ff + ROUND_HALF;
      quot    = rounded[SUM_W-1:29];
      priority if (quot > OUT_MAX) begin
         rsp_value_in = RESULT_W'(OUT_MAX);
         rsp_sat_in   = 1'b1;
      end else if (quot < OUT_MIN) begin
         rsp_value_in = RESULT_W'(OUT_MIN);
         rsp_sat_in   = 1'b1;
      end else begin
         rsp_value_in = quot[RESULT_W-1:0];
         rsp_sat_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
      rsp_sat_ff   <= rsp_sat_in;
   end

   // The pipeline takes a beat in every cycle.
   assign busy            = 1'b0;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_noise_value = rsp_value_ff;
   assign rsp_saturated   = rsp_sat_ff;

`ifndef ASSERT_OFF
   a_rsp_has_req : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, LATENCY))
      else $error("response beat without a request nine cycles earlier");

   a_req_gets_rsp : assert property (@(posedge clock) disable iff (reset)
      start |-> ##9 rsp_valid)
      else $error("request beat produced no response beat");

   a_sat_at_rail : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_saturated) |->
         (rsp_noise_value == RESULT_W'(OUT_MAX) || rsp_noise_value == RESULT_W'(OUT_MIN)))
      else $error("saturated response not at an output rail");
`endif

endmodule

[hdl/ovn_hash.sv]
// ----------------------------------------------------------------------------
// ovn_hash
// Three-stage pipelined integer hash of one lattice point to a value in
// (-1, 1] as signed Q2.30.
// ----------------------------------------------------------------------------
module ovn_hash (
   input  logic                                 clock,
   input  logic [ovn_pkg::LATTICE_W-1:0]        n,
   output logic signed [ovn_pkg::VALUE_W-1:0]   lattice_value
);
   import ovn_pkg::*;

   logic [31:0] n_ext;
   logic [31:0] m_in;
   logic [31:0] mm_in;
   logic [30:0] m1_ff;
   logic [30:0] mm1_ff;
   logic [30:0] m2_ff;
   logic [30:0] t2_ff;
   logic [30:0] t2_in;
   logic [30:0] h3_in;
   logic signed [VALUE_W-1:0] val3_ff;
   logic signed [VALUE_W-1:0] val3_in;

   // Only the low 31 bits of every product reach the masked hash.
   always_comb begin
      n_ext = 32'(n);
      m_in  = (n_ext << 13) ^ n_ext;
      mm_in = m_in * m_in;
      t2_in = mm1_ff * HASH_MUL + HASH_ADD1;
      h3_in = m2_ff * t2_ff + HASH_ADD2;
      val3_in = VALUE_ONE - $signed({1'b0, h3_in});
   end

   always_ff @(posedge clock) begin
      m1_ff   <= m_in[30:0];
      mm1_ff  <= mm_in[30:0];
      m2_ff   <= m1_ff;
      t2_ff   <= t2_in;
      val3_ff <= val3_in;
   end

   assign lattice_value = val3_ff;

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the octave value-noise block. A queue of positions
// feeds a clocked driver with random idle cycles between beats. An in-bench
// predictor computes each expected noise sample when its request beat is
// accepted, and a monitor checks every response beat field by field against
// the oldest prediction. The run sweeps register settings between phases.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import ovn_pkg::*;

   localparam int OCTAVES      = 4;
   localparam int TABLE_BITS   = 8;
   localparam int TABLE_SIZE   = 1 << TABLE_BITS;
   // Cycles waited after draining, to catch stray response beats.
   localparam int DRAIN_CYCLES = 16;

   localparam longint unsigned Q30_UNIT  = 64'd1 << 30;
   localparam longint unsigned PI_IN_Q30 = 64'd3373259426;
   localparam longint          NOISE_HI  = 524287;
   localparam longint          NOISE_LO  = -524288;

   // How the driver spaces the request beats of one phase.
   typedef enum int {
      IDLE_NONE,
      IDLE_ANY,
      IDLE_BURSTY
   } idle_style_type;

   typedef struct {
      logic [POSITION_W-1:0] position;
      int unsigned           idle_after;
   } position_beat_type;

   typedef struct {
      logic signed [RESULT_W-1:0] noise_value;
      logic                       saturated;
   } noise_sample_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       start = 1'b0;
   logic                       busy;
   logic [POSITION_W-1:0]      req_position = '0;
   logic                       rsp_valid;
   logic signed [RESULT_W-1:0] rsp_noise_value;
   logic                       rsp_saturated;
   logic                       csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]       csr_index = '0;
   logic [CSR_DATA_W-1:0]      csr_wdata = '0;

   // Positions waiting to be offered, predictions waiting for their response
   // beat, and response beats captured at the clock edge but not yet checked.
   position_beat_type positions_to_send[$];
   noise_sample_type  predicted_samples[$];
   noise_sample_type  observed_samples[$];

   // Bench copy of the configuration registers and the blend weight table.
   logic [BASE_W-1:0] base_log2_cfg;
   logic [GAIN_W-1:0] gain_cfg [OCTAVES];
   logic [16:0]       weight_lut [TABLE_SIZE];

   int unsigned idle_left = 0;
   int          mismatches = 0;

   octave_value_noise_1d #(
      .NUM_OCTAVES       (OCTAVES),
      .WEIGHT_TABLE_BITS (TABLE_BITS)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_position    (req_position),
      .rsp_valid       (rsp_valid),
      .rsp_noise_value (rsp_noise_value),
      .rsp_saturated   (rsp_saturated),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Raised-cosine weight (1 - cos(theta)) / 2 in Q0.16 for the lower half of
   // the table. The cosine is a six-step Horner series in Q2.30, evaluated
   // with truncating shifts and divides so that it matches the hardware table.
   function automatic longint unsigned cosine_half_weight(int unsigned j);
      longint unsigned theta;
      longint unsigned x2;
      longint unsigned r;
      longint unsigned t;
      longint unsigned w;
      longint unsigned divisors [6];
      divisors = '{64'd132, 64'd90, 64'd56, 64'd30, 64'd12, 64'd2};
      theta = (PI_IN_Q30 * j) >> TABLE_BITS;
      x2 = (theta * theta) >> 30;
      r = Q30_UNIT;
      for (int k = 0; k < 6; k++) begin
         t = ((x2 * r) >> 30) / divisors[k];
         r = (t > Q30_UNIT) ? 64'd0 : Q30_UNIT - t;
      end
      w = (Q30_UNIT - r + 64'd16384) >> 15;
      return (w > 64'd65536) ? 64'd65536 : w;
   endfunction

   // Hash of one lattice point with 32-bit wrap, mapped to (-1, 1] in Q2.30.
   function automatic longint lattice_value(int unsigned n);
      int unsigned m;
      int unsigned h;
      m = (n << 13) ^ n;
      h = (m * (m * m * 32'd15731 + 32'd789221) + 32'd1376312589) & 32'h7fff_ffff;
      return longint'(Q30_UNIT) - longint'(h);
   endfunction

   // Expected response for one position under the current register copy.
   // Each octave blends the values of the lattice points around the position,
   // scales the blend by its gain into Q45, and the octave terms are summed,
   // rounded half up to Q16 and clipped to the signed 20-bit range.
   function automatic noise_sample_type octave_noise_sample(logic [POSITION_W-1:0] position);
      int unsigned   base;
      int unsigned   p;
      int unsigned   fbits;
      int unsigned   lo;
      int unsigned   hi;
      int unsigned   offset;
      int unsigned   idx;
      longint        w;
      longint        gain;
      longint        blend;
      longint        acc;
      longint        rounded;
      noise_sample_type res;
      base = (base_log2_cfg < MIN_BASE_LOG2) ? MIN_BASE_LOG2 : base_log2_cfg;
      acc = 0;
      for (int k = 0; k < OCTAVES; k++) begin
         p = base - k;
         fbits = p + 8;
         lo = (32'(position) >> fbits) << p;
         hi = lo + (32'd1 << p);
         offset = 32'(position) & ((32'd1 << fbits) - 32'd1);
         if (fbits >= TABLE_BITS) begin
            idx = offset >> (fbits - TABLE_BITS);
         end else begin
            idx = offset << (TABLE_BITS - fbits);
         end
         w = weight_lut[idx & (TABLE_SIZE - 1)];
         gain = gain_cfg[k];
         // Arithmetic shift floors toward minus infinity.
         blend = (lattice_value(lo) * (65536 - w) + lattice_value(hi) * w) >>> 16;
         acc += blend * gain;
      end
      rounded = (acc + (longint'(1) << 28)) >>> 29;
      res.saturated = 1'b0;
      if (rounded > NOISE_HI) begin
         rounded = NOISE_HI;
         res.saturated = 1'b1;
      end else if (rounded < NOISE_LO) begin
         rounded = NOISE_LO;
         res.saturated = 1'b1;
      end
      res.noise_value = rounded[RESULT_W-1:0];
      return res;
   endfunction

   // Driver: offers one request beat at a time from the position queue. The
   // prediction is made at the very edge that accepts the beat, so it always
   // uses the registers in force for that beat. After each beat the driver
   // keeps start low for the idle count drawn with it.
   always @(posedge clock) begin : drive_positions
      position_beat_type beat;
      if (reset) begin
         start <= 1'b0;
         idle_left = 0;
      end else begin
         if (start && !busy) begin
            predicted_samples.insert(predicted_samples.size(),
                                     octave_noise_sample(req_position));
         end
         if (!(start && busy)) begin
            if (idle_left != 0) begin
               idle_left--;
               start <= 1'b0;
            end else if (positions_to_send.size() != 0) begin
               beat = positions_to_send.pop_front();
               start <= 1'b1;
               req_position <= beat.position;
               idle_left = beat.idle_after;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor: a response beat is taken at the edge that ends its strobe cycle.
   // The check itself runs on the falling edge, once every process of the
   // rising edge is done, so a prediction made at the same edge is in place.
   always @(posedge clock) begin : capture_results
      noise_sample_type seen;
      if (!reset && rsp_valid) begin
         seen.noise_value = rsp_noise_value;
         seen.saturated = rsp_saturated;
         observed_samples.insert(observed_samples.size(), seen);
      end
   end

   always @(negedge clock) begin : compare_results
      noise_sample_type got;
      noise_sample_type want;
      if (observed_samples.size() != 0) begin
         got = observed_samples.pop_front();
         if (predicted_samples.size() == 0) begin
            $display("%0t: response beat with no request pending: expected none, got %0d/%0b",
                     $time, got.noise_value, got.saturated);
            mismatches++;
         end else begin
            want = predicted_samples.pop_front();
            if (got.noise_value !== want.noise_value) begin
               $display("%0t: noise_value mismatch: expected %0d, got %0d",
                        $time, want.noise_value, got.noise_value);
               mismatches++;
            end
            if (got.saturated !== want.saturated) begin
               $display("%0t: saturated mismatch: expected %0b, got %0b",
                        $time, want.saturated, got.saturated);
               mismatches++;
            end
         end
      end
   end

   // Waits until every queued position has been accepted and every response
   // beat has arrived and been checked. Sampling one unit after the edge sees
   // the settled values of all processes of that edge.
   task automatic wait_until_drained();
      do begin
         @(posedge clock);
         #1;
      end while (positions_to_send.size() != 0 || start ||
                 predicted_samples.size() != 0 || observed_samples.size() != 0);
   endtask

   // One register write; the bench copy follows the same decode as the block,
   // so writes to unmapped indexes leave it untouched.
   task automatic write_csr(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      if (index == CSR_BASE_LOG2) begin
         base_log2_cfg = data[BASE_W-1:0];
      end else if (index >= CSR_GAIN0 && index <= CSR_GAIN3) begin
         gain_cfg[index - CSR_GAIN0] = data;
      end
   endtask

   task automatic end_csr_writes();
      @(posedge clock);
      csr_we <= 1'b0;
      #1;
   endtask

   // Registers change only with the pipeline empty.
   task automatic program_setting(logic [CSR_DATA_W-1:0] base_word,
                                  logic [GAIN_W-1:0] g0, logic [GAIN_W-1:0] g1,
                                  logic [GAIN_W-1:0] g2, logic [GAIN_W-1:0] g3);
      wait_until_drained();
      write_csr(CSR_BASE_LOG2, base_word);
      write_csr(CSR_GAIN0, g0);
      write_csr(CSR_GAIN1, g1);
      write_csr(CSR_GAIN2, g2);
      write_csr(CSR_GAIN3, g3);
      end_csr_writes();
   endtask

   function automatic logic [GAIN_W-1:0] pick_gain();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         default: return GAIN_W'($urandom);
      endcase
   endfunction

   // Random positions for one phase. A share of them lands exactly on a
   // coarse lattice point, on the last step before one, near the origin or
   // near the top of the range; the rest are uniform over all 24 bits.
   task automatic queue_random_positions(int count, idle_style_type idle_style);
      position_beat_type beat;
      int unsigned    span;
      span = ((base_log2_cfg < MIN_BASE_LOG2) ? MIN_BASE_LOG2 : base_log2_cfg) + 8;
      for (int i = 0; i < count; i++) begin
         beat.position = POSITION_W'($urandom);
         case ($urandom_range(0, 7))
            0: beat.position = (beat.position >> span) << span;
            1: beat.position = beat.position | ((POSITION_W'(1) << span) - 1'b1);
            2: beat.position = POSITION_W'($urandom_range(0, 1023));
            3: beat.position = beat.position | 24'hFF0000;
            default: ;
         endcase
         case (idle_style)
            IDLE_NONE: beat.idle_after = 0;
            IDLE_ANY:  beat.idle_after = $urandom_range(0, 15);
            default:   beat.idle_after = ($urandom_range(0, 3) == 0) ?
                                         $urandom_range(0, 15) : 0;
         endcase
         positions_to_send.insert(positions_to_send.size(), beat);
      end
   endtask

   initial begin : stimulus
      position_beat_type     beat;
      logic [POSITION_W-1:0] corner [16];

      // The table is mirrored about its middle entry, as in the hardware.
      for (int i = 0; i < TABLE_SIZE; i++) begin
         if (i <= TABLE_SIZE / 2) begin
            weight_lut[i] = 17'(cosine_half_weight(i));
         end else begin
            weight_lut[i] = 17'(64'd65536 - cosine_half_weight(TABLE_SIZE - i));
         end
      end
      base_log2_cfg = BASE_RESET;
      gain_cfg[0] = GAIN0_RESET;
      gain_cfg[1] = GAIN1_RESET;
      gain_cfg[2] = GAIN2_RESET;
      gain_cfg[3] = GAIN3_RESET;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      #1;

      // Directed beats under the reset registers (coarse period 2^7 units, so
      // 15 fraction bits). They cover both ends of the range, the smallest
      // fraction, exact lattice points of the coarse and finest octaves, the
      // half-period point, the step just below a lattice point and
      // alternating bit patterns. The first half goes back to back.
      corner = '{24'h000000, 24'hFFFFFF, 24'h000001, 24'h0000FF,
                 24'h000100, 24'h004000, 24'h007FFF, 24'h008000,
                 24'h008080, 24'h7FFFFF, 24'h800000, 24'hFF8000,
                 24'h555555, 24'hAAAAAA, 24'h001000, 24'h123456};
      for (int i = 0; i < 16; i++) begin
         beat.position = corner[i];
         beat.idle_after = (i < 8) ? 0 : i;
         positions_to_send.insert(positions_to_send.size(), beat);
      end

      // Finest allowed period with every gain at full scale, then the
      // coarsest period with full gains.
      program_setting(16'd3, '1, '1, '1, '1);
      queue_random_positions(100, IDLE_NONE);
      program_setting(16'd15, '1, '1, '1, '1);
      queue_random_positions(100, IDLE_ANY);

      // Periods below the minimum are taken as the minimum; the upper data
      // bits of the period register are dropped. All gains at zero.
      program_setting(16'hFFF0, '0, '0, '0, '0);
      queue_random_positions(100, IDLE_BURSTY);
      program_setting(16'd1, pick_gain(), pick_gain(), pick_gain(), pick_gain());
      queue_random_positions(100, IDLE_ANY);
      program_setting(16'hA5A2, '1, '0, '1, '0);
      queue_random_positions(100, IDLE_NONE);

      // Writes to the unmapped indexes must leave every register as it was.
      wait_until_drained();
      for (int idx = CSR_GAIN3 + 1; idx < (1 << CSR_IDX_W); idx++) begin
         write_csr(CSR_IDX_W'(idx), CSR_DATA_W'($urandom));
      end
      end_csr_writes();
      queue_random_positions(100, IDLE_BURSTY);

      // Random settings. Each phase boundary also holds the sender off until
      // every outstanding response beat has come back.
      for (int ph = 0; ph < 9; ph++) begin
         program_setting({12'($urandom), 4'($urandom_range(3, 15))},
                         pick_gain(), pick_gain(), pick_gain(), pick_gain());
         queue_random_positions(100, idle_style_type'(ph % 3));
      end

      wait_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      #1;
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Ends the run with a failure if it hangs.
   initial begin : watchdog
      #3_000_000;
      $display("%0t: timeout waiting for request or response beats", $time);
      $display("*** FAILED ***");
      $finish;
   end

endmodule

[files.f]
hdl/ovn_pkg.sv
hdl/ovn_hash.sv
hdl/octave_value_noise_1d.sv
tb/tb_top.sv
